>>> rtl/fntt_pkg.sv
// ----------------------------------------------------------------------------
// fntt_pkg
// Shared types and constants of the forward NTT block.
// ----------------------------------------------------------------------------
package fntt_pkg;

   // Coefficient width and the width of one modular product.
   localparam int DATA_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   // Width of the step counter of the shift-subtract reducer, one dividend bit per step.
   localparam int RED_CNT_W = $clog2(PROD_W + 1);

   // Configuration register indexes.
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_ROOT    = 1'b1;

   // Register reset values.
   localparam logic [DATA_W-1:0] MODULUS_RESET = 16'd11777;
   localparam logic [DATA_W-1:0] ROOT_RESET    = 16'd5558;

   // Status of the shared modular reducer.
   typedef struct packed {
      logic busy;
      logic done;
   } red_status_type;

endpackage

>>> rtl/fntt_ram.sv
// ----------------------------------------------------------------------------
// fntt_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fntt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/fntt_modred.sv
// ----------------------------------------------------------------------------
// fntt_modred
// Iterative modular reducer: remainder of a 32-bit dividend by a 16-bit
// modulus, one dividend bit per cycle by restoring shift and subtract.
// ----------------------------------------------------------------------------
module fntt_modred (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fntt_pkg::PROD_W-1:0]  dividend,
   input  logic [fntt_pkg::DATA_W-1:0]  modulus,
   output fntt_pkg::red_status_type     status,
   output logic [fntt_pkg::DATA_W-1:0]  remainder
);
   import fntt_pkg::*;

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = RED_CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, modulus}) begin
            rem_in = DATA_W'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[DATA_W-1:0];
         end
         quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == RED_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;
endmodule

>>> rtl/forward_ntt_cooley_tukey.sv
// ----------------------------------------------------------------------------
// forward_ntt_cooley_tukey
// Radix-2 Cooley-Tukey forward number-theoretic transform over POINTS
// coefficients, built around one multiplier and one iterative reducer.
//
//   Channel | Direction | Ports                                  | Beat
//   req     | in        | req_valid req_stall req_coefficient    | one coefficient
//   rsp     | out       | rsp_valid rsp_stall rsp_value/position | one transformed value
//           |           | rsp_final_res                          |
//   csr     | in        | csr_write csr_index csr_wdata          | one register write
//
// Each coefficient beat is reduced before the next one is taken; the
// reducer works one bit per cycle over 32 steps. After the last beat of a
// frame the block builds the twiddles (POINTS reductions), normalizes the
// store (POINTS reductions) and runs POINTS/2*log2(POINTS) butterflies.
// Results then leave one beat at a time; the next beat is read only after
// the current one is taken with rsp_stall low. req_stall is low only in idle.
// Reset is synchronous: it clears control state and resets both registers.
// ----------------------------------------------------------------------------
module forward_ntt_cooley_tukey #(
   parameter int POINTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fntt_pkg::DATA_W-1:0] req_coefficient,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fntt_pkg::DATA_W-1:0] rsp_value,
   output logic [5:0]                  rsp_position,
   output logic                        rsp_final_res,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [fntt_pkg::DATA_W-1:0] csr_wdata
);
   import fntt_pkg::*;

   localparam int PW = $clog2(POINTS);
   localparam logic [PW-1:0] LAST = PW'(POINTS - 1);

   typedef enum logic [20:0] {
      ST_IDLE   = 21'h000001,
      ST_LD_GO  = 21'h000002,
      ST_LD_WT  = 21'h000004,
      ST_RT_GO  = 21'h000008,
      ST_RT_WT  = 21'h000010,
      ST_TW_WR  = 21'h000020,
      ST_TW_MUL = 21'h000040,
      ST_TW_GO  = 21'h000080,
      ST_TW_WT  = 21'h000100,
      ST_NM_RD  = 21'h000200,
      ST_NM_GO  = 21'h000400,
      ST_NM_WT  = 21'h000800,
      ST_BF_A   = 21'h001000,
      ST_BF_B   = 21'h002000,
      ST_BF_M   = 21'h004000,
      ST_BF_GO  = 21'h008000,
      ST_BF_WT  = 21'h010000,
      ST_BF_WA  = 21'h020000,
      ST_OUT_RD = 21'h040000,
      ST_OUT_LD = 21'h080000,
      ST_OUT_WT = 21'h100000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] modulus_ff, root_ff;
   logic [PW-1:0]     load_cnt_ff, load_cnt_in;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     half_ff, half_in, base_ff, base_in, off_ff, off_in, k_ff, k_in;
   logic [DATA_W-1:0] coef_ff, coef_in, w_ff, w_in, acc_ff, acc_in;
   logic [DATA_W-1:0] a_ff, a_in, sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PW-1:0]     rsp_pos_ff, rsp_pos_in;
   logic              rsp_final_ff, rsp_final_in;

   logic [DATA_W-1:0] em;
   logic [PW-1:0]     j_idx, hi_idx, idx_rev;
   logic [PW:0]       base_next;
   logic [DATA_W:0]   sum_wide, diff_wide;

   // Shared reducer and the two stores.
   logic              red_start;
   logic [PROD_W-1:0] red_dividend;
   red_status_type    red_status;
   logic [DATA_W-1:0] red_rem;
   logic              c_we, t_we;
   logic [PW-1:0]     c_waddr, c_raddr;
   logic [DATA_W-1:0] c_wdata, c_rdata, t_rdata;

   fntt_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (red_dividend),
      .modulus   (em),
      .status    (red_status),
      .remainder (red_rem)
   );

   fntt_ram #(.WIDTH(DATA_W), .DEPTH(POINTS)) u_coeff_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   fntt_ram #(.WIDTH(DATA_W), .DEPTH(POINTS)) u_twiddle_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (idx_rev),
      .wdata (acc_ff),
      .raddr (k_ff),
      .rdata (t_rdata)
   );

   // A zero modulus acts as one.
   assign em = (modulus_ff == '0) ? DATA_W'(1) : modulus_ff;

   // Butterfly addresses and the modular sum and difference.
   assign j_idx     = base_ff + off_ff;
   assign hi_idx    = j_idx + half_ff;
   assign base_next = {1'b0, base_ff} + {half_ff, 1'b0};
   assign sum_wide  = {1'b0, a_ff} + {1'b0, red_rem};
   assign diff_wide = {1'b0, a_ff} + {1'b0, em} - {1'b0, red_rem};

   // Bit-reversed twiddle write address.
   always_comb begin
      for (int i = 0; i < PW; i++) begin
         idx_rev[i] = idx_ff[PW-1-i];
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      idx_in       = idx_ff;
      half_in      = half_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      k_in         = k_ff;
      coef_in      = coef_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_final_in = rsp_final_ff;
      red_start    = 1'b0;
      red_dividend = prod_ff;
      c_we         = 1'b0;
      c_waddr      = idx_ff;
      c_wdata      = red_rem;
      c_raddr      = idx_ff;
      t_we         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               coef_in  = req_coefficient;
               state_in = ST_LD_GO;
            end
         end
         // Reduce the coefficient under the modulus now in force.
         ST_LD_GO: begin
            red_start    = 1'b1;
            red_dividend = PROD_W'(coef_ff);
            state_in     = ST_LD_WT;
         end
         ST_LD_WT: begin
            c_waddr = load_cnt_ff;
            if (red_status.done) begin
               c_we        = 1'b1;
               load_cnt_in = load_cnt_ff + 1'b1;
               state_in    = (load_cnt_ff == LAST) ? ST_RT_GO : ST_IDLE;
            end
         end
         // Twiddle table: successive powers of the reduced root.
         ST_RT_GO: begin
            red_start    = 1'b1;
            red_dividend = PROD_W'(root_ff);
            state_in     = ST_RT_WT;
         end
         ST_RT_WT: begin
            if (red_status.done) begin
               w_in     = red_rem;
               acc_in   = (em == DATA_W'(1)) ? '0 : DATA_W'(1);
               idx_in   = '0;
               state_in = ST_TW_WR;
            end
         end
         ST_TW_WR: begin
            t_we = 1'b1;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = ST_NM_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TW_MUL;
            end
         end
         ST_TW_MUL: begin
            prod_in  = acc_ff * w_ff;
            state_in = ST_TW_GO;
         end
         ST_TW_GO: begin
            red_start = 1'b1;
            state_in  = ST_TW_WT;
         end
         ST_TW_WT: begin
            if (red_status.done) begin
               acc_in   = red_rem;
               state_in = ST_TW_WR;
            end
         end
         // Bring every stored coefficient below the final modulus.
         ST_NM_RD: begin
            state_in = ST_NM_GO;
         end
         ST_NM_GO: begin
            red_start    = 1'b1;
            red_dividend = PROD_W'(c_rdata);
            state_in     = ST_NM_WT;
         end
         ST_NM_WT: begin
            if (red_status.done) begin
               c_we = 1'b1;
               if (idx_ff == LAST) begin
                  half_in  = PW'(POINTS / 2);
                  base_in  = '0;
                  off_in   = '0;
                  k_in     = PW'(1);
                  state_in = ST_BF_A;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_NM_RD;
               end
            end
         end
         // Butterfly: read a, read b, multiply by the twiddle, reduce, write back both.
         ST_BF_A: begin
            c_raddr  = j_idx;
            state_in = ST_BF_B;
         end
         ST_BF_B: begin
            c_raddr  = hi_idx;
            a_in     = c_rdata;
            state_in = ST_BF_M;
         end
         ST_BF_M: begin
            prod_in  = t_rdata * c_rdata;
            state_in = ST_BF_GO;
         end
         ST_BF_GO: begin
            red_start = 1'b1;
            state_in  = ST_BF_WT;
         end
         ST_BF_WT: begin
            c_waddr = hi_idx;
            c_wdata = diff_wide >= {1'b0, em} ? DATA_W'(diff_wide - {1'b0, em})
                                              : diff_wide[DATA_W-1:0];
            if (red_status.done) begin
               c_we     = 1'b1;
               sum_in   = sum_wide >= {1'b0, em} ? DATA_W'(sum_wide - {1'b0, em})
                                                 : sum_wide[DATA_W-1:0];
               state_in = ST_BF_WA;
            end
         end
         ST_BF_WA: begin
            c_we     = 1'b1;
            c_waddr  = j_idx;
            c_wdata  = sum_ff;
            state_in = ST_BF_A;
            if (off_ff + 1'b1 == half_ff) begin
               off_in = '0;
               k_in   = k_ff + 1'b1;
               if (base_next == (PW + 1)'(POINTS)) begin
                  base_in = '0;
                  if (half_ff == PW'(1)) begin
                     idx_in   = '0;
                     state_in = ST_OUT_RD;
                  end else begin
                     half_in = half_ff >> 1;
                  end
               end else begin
                  base_in = base_next[PW-1:0];
               end
            end else begin
               off_in = off_ff + 1'b1;
            end
         end
         // Stream the transformed values in index order.
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = c_rdata;
            rsp_pos_in   = idx_ff;
            rsp_final_in = (idx_ff == LAST);
            state_in     = ST_OUT_WT;
         end
         ST_OUT_WT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (idx_ff == LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration registers and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
         root_ff      <= ROOT_RESET;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MODULUS: modulus_ff <= csr_wdata;
               CSR_ROOT:    root_ff    <= csr_wdata;
               default:     root_ff    <= root_ff;
            endcase
         end
      end
      idx_ff       <= idx_in;
      half_ff      <= half_in;
      base_ff      <= base_in;
      off_ff       <= off_in;
      k_ff         <= k_in;
      coef_ff      <= coef_in;
      w_ff         <= w_in;
      acc_ff       <= acc_in;
      a_ff         <= a_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_position  = 6'(rsp_pos_ff);
   assign rsp_final_res = rsp_final_ff;
endmodule

>>> rtl/fntt_checker.sv
// ----------------------------------------------------------------------------
// fntt_checker
// Port-level checks of the forward NTT block, bound to its top level.
// ----------------------------------------------------------------------------
module fntt_checker #(
   parameter int POINTS = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [fntt_pkg::DATA_W-1:0] rsp_value,
   input logic [5:0]                  rsp_position,
   input logic                        rsp_final_res
);
   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_value))
      else $error("result value changed while stalled");

   // No coefficient is taken while results are being delivered.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input ready during result delivery");

   // The last beat of a transform carries the last position.
   a_final_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> rsp_position == 6'(POINTS - 1))
      else $error("final beat at wrong position");
endmodule

bind forward_ntt_cooley_tukey fntt_checker #(.POINTS(POINTS)) u_fntt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_value     (rsp_value),
   .rsp_position  (rsp_position),
   .rsp_final_res (rsp_final_res)
);

>>> verif/forward_ntt_cooley_tukey_checker.sv
// ----------------------------------------------------------------------------
// forward_ntt_cooley_tukey_checker
// Watches the coefficient and result channels of the forward NTT block,
// predicts every transformed value from its own model of the transform and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module forward_ntt_cooley_tukey_checker #(
   parameter int POINTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [fntt_pkg::DATA_W-1:0] req_coefficient,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [fntt_pkg::DATA_W-1:0] rsp_value,
   input  logic [5:0]                  rsp_position,
   input  logic                        rsp_final_res,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [fntt_pkg::DATA_W-1:0] csr_wdata,
   output int                          fail_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fntt_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [5:0]        position;
      logic              final_res;
   } ntt_result_type;

   localparam int LOG_POINTS = $clog2(POINTS);

   logic [DATA_W-1:0] modulus_reg;
   logic [DATA_W-1:0] root_reg;
   logic [DATA_W-1:0] frame_coeffs [POINTS];
   int                loaded;
   ntt_result_type    expected_results [$];

   function automatic int unsigned reverse_bits(int unsigned k);
      int unsigned r;
      r = 0;
      for (int i = 0; i < LOG_POINTS; i++) r |= ((k >> i) & 1) << (LOG_POINTS - 1 - i);
      return r;
   endfunction

   // Runs the full frame transform and queues the POINTS expected beats.
   task automatic predict_transform();
      longint unsigned m, w, acc, a, b, t;
      longint unsigned twiddle [POINTS];
      longint unsigned data [POINTS];
      int                k;
      ntt_result_type    r;
      m = (modulus_reg == 0) ? 1 : modulus_reg;
      w = root_reg % m;
      for (int i = 0; i < POINTS; i++) begin
         acc = 1 % m;
         for (int e = 0; e < reverse_bits(i); e++) acc = (acc * w) % m;
         twiddle[i] = acc;
         data[i] = frame_coeffs[i];
      end
      k = 1;
      for (int half = POINTS / 2; half > 0; half /= 2) begin
         for (int start = 0; start < POINTS; start += 2 * half) begin
            for (int j = start; j < start + half; j++) begin
               a = data[j];
               b = data[j + half];
               t = (twiddle[k] * b) % m;
               data[j + half] = (a + m - t) % m;
               data[j] = (a + t) % m;
            end
            k++;
         end
      end
      for (int i = 0; i < POINTS; i++) begin
         r.value = DATA_W'(data[i]);
         r.position = 6'(i);
         r.final_res = (i == POINTS - 1);
         expected_results = {expected_results, r};
      end
   endtask

   always @(posedge clock) begin
      ntt_result_type exp_r;
      longint unsigned m;
      if (reset) begin
         modulus_reg = MODULUS_RESET;
         root_reg = ROOT_RESET;
         loaded = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         // Register writes land at the same edge as any coefficient beat.
         if (csr_write) begin
            if (csr_index == CSR_MODULUS) modulus_reg = csr_wdata;
            else if (csr_index == CSR_ROOT) root_reg = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            m = (modulus_reg == 0) ? 1 : modulus_reg;
            frame_coeffs[loaded] = DATA_W'(req_coefficient % m);
            loaded++;
            if (loaded == POINTS) begin
               predict_transform();
               loaded = 0;
            end
         end
         // Compare each result beat with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat: value %0d pos %0d",
                                              rsp_value, rsp_position);
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r !== {rsp_value, rsp_position, rsp_final_res}) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected value %0d pos %0d final %0b, got %0d %0d %0b",
                              exp_r.value, exp_r.position, exp_r.final_res,
                              rsp_value, rsp_position, rsp_final_res);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

>>> verif/forward_ntt_cooley_tukey_tb.sv
// ----------------------------------------------------------------------------
// forward_ntt_cooley_tukey_tb
// Feeds frames of coefficients to the forward NTT block under several
// modulus and root settings with random sender gaps and receiver stalls;
// the checker predicts and compares every transformed value.
// ----------------------------------------------------------------------------
module forward_ntt_cooley_tukey_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fntt_pkg::*;

   localparam int POINTS = 32;
   localparam int IDLE_LIMIT = 200000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [DATA_W-1:0] req_coefficient;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DATA_W-1:0] rsp_value;
   logic [5:0]        rsp_position;
   logic              rsp_final_res;
   logic              csr_write;
   logic              csr_index;
   logic [DATA_W-1:0] csr_wdata;
   int                fail_count;
   int                pending_count;
   int                idle_cycles;
   int                burst_left;
   bit                stall_enable;

   forward_ntt_cooley_tukey #(.POINTS(POINTS)) dut (.*);
   forward_ntt_cooley_tukey_checker #(.POINTS(POINTS)) checker_inst (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver stall pattern: random phases of heavy stall and free flow.
   initial begin
      rsp_stall = 0;
      stall_enable = 1;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) stall_enable = ~stall_enable;
         rsp_stall <= stall_enable ? ($urandom_range(0, 3) == 0) : 1'b0;
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("forward_ntt_cooley_tukey verification failed");
         $finish;
      end
   end

   // Sends one coefficient beat, honoring bursts and gaps.
   task automatic send_coefficient(logic [DATA_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1;
      req_coefficient <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_frame(int kind);
      logic [DATA_W-1:0] c;
      for (int i = 0; i < POINTS; i++) begin
         case (kind)
            0: c = 16'hFFFF;
            1: c = 16'h0000;
            2: c = (i == 0) ? 16'd1 : 16'd0;
            default: c = DATA_W'($urandom_range(0, 65535));
         endcase
         send_coefficient(c);
      end
      req_valid <= 0;
   endtask

   // Waits for every result, then idles a while before any register write.
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [DATA_W-1:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_coefficient = 0;
      csr_write = 0;
      csr_index = CSR_MODULUS;
      csr_wdata = 0;
      burst_left = 0;
      repeat (10) @(negedge clock);
      reset = 0;
      // Directed: reset settings, impulse with root above modulus, modulus one.
      send_frame(0);
      drain();
      write_reg(CSR_MODULUS, 16'd65521);
      write_reg(CSR_ROOT, 16'd65534);
      send_frame(2);
      drain();
      write_reg(CSR_MODULUS, 16'd1);
      send_frame(3);
      drain();
      // Random frames under a zero modulus and under random settings.
      for (int f = 0; f < 2; f++) begin
         case (f)
            0: begin write_reg(CSR_MODULUS, 16'd0); write_reg(CSR_ROOT, 16'd5558); end
            default: begin
               write_reg(CSR_MODULUS, DATA_W'($urandom_range(3, 65535)));
               write_reg(CSR_ROOT, DATA_W'($urandom_range(1, 65534)));
            end
         endcase
         send_frame(3);
         drain();
      end
      if (fail_count == 0) $display("forward_ntt_cooley_tukey verification clean");
      else $display("forward_ntt_cooley_tukey verification failed");
      $finish;
   end

endmodule
